// ===== design/psfs_pkg.sv =====
// shared constants and types for the position sample filter and scaler
package psfs_pkg;

  // fixed field widths
  localparam int POS_BITS   = 12;
  localparam int PCT_BITS   = 15;
  localparam int IN_BITS    = 12;
  localparam int PROD_BITS  = 27;
  localparam int CFG_BITS   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int ITER_BITS  = 5;

  // parameter defaults
  localparam int RING_TAPS_DEF   = 5;
  localparam int SAMPLE_BITS_DEF = 12;

  // register reset values and scale
  localparam logic [POS_BITS-1:0] LOWER_RESET   = 12'd100;
  localparam logic [POS_BITS-1:0] UPPER_RESET   = 12'd3900;
  localparam logic [PCT_BITS-1:0] FULL_SCALE_Q8 = 15'd25600;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER = 2'd0,
    CFG_UPPER = 2'd1,
    CFG_CAL   = 2'd2
  } cfg_idx_t;

  // divider launch control
  typedef struct packed {
    logic                 start;
    logic [ITER_BITS-1:0] iters;
  } div_ctl_t;

endpackage

// ===== design/position_sample_filter_scaler.sv =====
// Good sample: the one bit-serial divider forms the ring mean (SAMPLE_BITS steps) and then
// the Q8 percentage (15 steps); no new input transfer is taken until the result is loaded
// into the output register. Errored sample skips the mean. A saturated or uncalibrated
// percentage skips the second division; a result still held in the output register stalls the next.
// Reset (synchronous, rst_n low) clears the ring, its running sum, slot and position.
module position_sample_filter_scaler
  import psfs_pkg::*;
#(
  parameter int RING_TAPS   = RING_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [11:0] sample_value, [15:12] zero
  input  logic                 in_tuser,   // [0] sample_failed
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [11:0] position_value, [26:12] percent_q8
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata
);

  localparam int SLOT_W = (RING_TAPS > 1) ? $clog2(RING_TAPS) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(RING_TAPS);
  localparam int QMAX   = (SAMPLE_BITS > PCT_BITS) ? SAMPLE_BITS : PCT_BITS;
  localparam int CMP_W  = (SAMPLE_BITS > POS_BITS) ? SAMPLE_BITS : POS_BITS;
  localparam int EXT_W  = (SAMPLE_BITS > IN_BITS) ? SAMPLE_BITS : IN_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_SCALE,
    ST_PCT,
    ST_DONE
  } state_t;

  state_t                 state_r;
  logic [SAMPLE_BITS-1:0] ring_r [RING_TAPS];
  logic [SLOT_W-1:0]      slot_r;
  logic [SUM_W-1:0]       sum_r;
  logic [POS_BITS-1:0]    pos_r;
  logic [PCT_BITS-1:0]    pct_r;
  logic [POS_BITS-1:0]    lower_r;
  logic [POS_BITS-1:0]    upper_r;
  logic                   cal_r;
  logic                   out_tvalid_r;
  logic [POS_BITS-1:0]    out_pos_r;
  logic [PCT_BITS-1:0]    out_pct_r;

  logic                   in_xfer;
  logic                   good_xfer;
  logic [EXT_W-1:0]       sample_ext;
  logic [SAMPLE_BITS-1:0] sample_new;
  logic [SUM_W-1:0]       sum_nxt;
  logic [SLOT_W-1:0]      slot_nxt;

  logic [SAMPLE_BITS-1:0] mean;
  logic [CMP_W-1:0]       mean_ext;
  logic [POS_BITS-1:0]    clamp_pos;

  logic                   pct_zero;
  logic                   pct_full;
  logic [POS_BITS-1:0]    delta;
  logic [PROD_BITS-1:0]   prod;
  logic [POS_BITS-1:0]    span;

  div_ctl_t               div_ctl;
  logic [POS_BITS-1:0]    div_rem_init;
  logic [QMAX-1:0]        div_low_init;
  logic [POS_BITS-1:0]    div_divisor;
  logic [QMAX-1:0]        div_quot;
  logic                   div_done;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign good_xfer = in_xfer && !in_tuser;

  // new sample into the running ring sum
  always_comb begin
    sample_ext = EXT_W'(in_tdata[IN_BITS-1:0]);
    sample_new = sample_ext[SAMPLE_BITS-1:0];
    sum_nxt    = sum_r - SUM_W'(ring_r[slot_r]) + SUM_W'(sample_new);
    slot_nxt   = (slot_r == SLOT_W'(RING_TAPS - 1)) ? '0 : slot_r + 1'b1;
  end

  // clamp the mean between the limits
  always_comb begin
    mean     = div_quot[SAMPLE_BITS-1:0];
    mean_ext = CMP_W'(mean);
    if (mean_ext < CMP_W'(lower_r)) begin
      clamp_pos = lower_r;
    end else if (mean_ext > CMP_W'(upper_r)) begin
      clamp_pos = upper_r;
    end else begin
      clamp_pos = POS_BITS'(mean);
    end
  end

  // percentage end points and scaled dividend, pos * 25600 as shifts
  always_comb begin
    pct_zero = !cal_r || (pos_r <= lower_r);
    pct_full = pos_r >= upper_r;
    delta    = pos_r - lower_r;
    span     = upper_r - lower_r;
    prod     = (PROD_BITS'(delta) << 14) + (PROD_BITS'(delta) << 13)
             + (PROD_BITS'(delta) << 10);
  end

  // divider launch: mean on a good sample, percentage inside the span
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.iters = ITER_BITS'(PCT_BITS);
    div_rem_init  = prod[PROD_BITS-1:PCT_BITS];
    div_low_init  = QMAX'(prod[PCT_BITS-1:0]) << (QMAX - PCT_BITS);
    div_divisor   = span;
    if (state_r == ST_IDLE) begin
      div_ctl.start = good_xfer;
      div_ctl.iters = ITER_BITS'(SAMPLE_BITS);
      div_rem_init  = POS_BITS'(sum_nxt[SUM_W-1:SAMPLE_BITS]);
      div_low_init  = QMAX'(sum_nxt[SAMPLE_BITS-1:0]) << (QMAX - SAMPLE_BITS);
      div_divisor   = POS_BITS'(RING_TAPS);
    end else if (state_r == ST_SCALE) begin
      div_ctl.start = !pct_zero && !pct_full;
    end
  end

  psfs_div #(
    .VW (POS_BITS),
    .QW (QMAX)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .low_init (div_low_init),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .done     (div_done)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
      cal_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER: lower_r <= cfg_wdata[POS_BITS-1:0];
        CFG_UPPER: upper_r <= cfg_wdata[POS_BITS-1:0];
        CFG_CAL:   cal_r   <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  // sequencer, ring state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      sum_r        <= '0;
      pos_r        <= '0;
      pct_r        <= '0;
      out_tvalid_r <= 1'b0;
      out_pos_r    <= '0;
      out_pct_r    <= '0;
      for (int i = 0; i < RING_TAPS; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      // result transfer frees the output register unless a new result loads it
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (good_xfer) begin
            ring_r[slot_r] <= sample_new;
            sum_r          <= sum_nxt;
            slot_r         <= slot_nxt;
            state_r        <= ST_MEAN;
          end else if (in_xfer) begin
            state_r <= ST_SCALE;
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            pos_r   <= clamp_pos;
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (pct_zero) begin
            pct_r   <= '0;
            state_r <= ST_DONE;
          end else if (pct_full) begin
            pct_r   <= FULL_SCALE_Q8;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_PCT;
          end
        end
        ST_PCT: begin
          if (div_done) begin
            pct_r   <= div_quot[PCT_BITS-1:0];
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_pos_r    <= pos_r;
            out_pct_r    <= pct_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_pct_r, out_pos_r};

`ifndef NO_ASSERTIONS
  // ring write pointer stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(RING_TAPS - 1))
    else $error("ring slot out of range");

  // divider completion only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_MEAN || state_r == ST_PCT))
    else $error("divider done outside a wait state");

  // with ordered limits a fresh position lies between them
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MEAN && div_done && lower_r <= upper_r)
      |=> (pos_r >= lower_r && pos_r <= upper_r))
    else $error("position outside limits");

  // percentage never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_pct_r <= FULL_SCALE_Q8)
    else $error("percentage above full scale");
`endif

endmodule

// ===== design/psfs_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module psfs_div
  import psfs_pkg::*;
#(
  parameter int VW = POS_BITS,
  parameter int QW = PCT_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  div_ctl_t      ctl,
  input  logic [VW-1:0] rem_init,
  input  logic [QW-1:0] low_init,
  input  logic [VW-1:0] divisor,
  output logic [QW-1:0] quot,
  output logic          done
);

  logic                 busy_r;
  logic [ITER_BITS-1:0] cnt_r;
  logic [VW-1:0]        rem_r;
  logic [QW-1:0]        sh_r;
  logic [VW-1:0]        div_r;

  logic [VW+1:0]        diff;
  logic                 ge;
  logic [VW-1:0]        rem_nxt;
  logic [QW-1:0]        sh_nxt;

  // trial subtract of the divisor from the partial remainder
  always_comb begin
    diff    = {1'b0, rem_r, sh_r[QW-1]} - {2'b00, div_r};
    ge      = ~diff[VW+1];
    rem_nxt = ge ? diff[VW-1:0] : {rem_r[VW-2:0], sh_r[QW-1]};
    sh_nxt  = {sh_r[QW-2:0], ge};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= ctl.iters;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= rem_init;
      sh_r  <= low_init;
      div_r <= divisor;
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign quot = sh_r;
  assign done = busy_r && (cnt_r == '0);

endmodule
